// File: rtl/gcpb_pkg.sv
`default_nettype none

package gcpb_pkg;

  // Pixel format codes
  localparam logic [3:0] FMT_Y8       = 4'd0;
  localparam logic [3:0] FMT_RGB24    = 4'd1;
  localparam logic [3:0] FMT_BGR24    = 4'd2;
  localparam logic [3:0] FMT_RGBA32   = 4'd3;
  localparam logic [3:0] FMT_BGRA32   = 4'd4;
  localparam logic [3:0] FMT_ARGB32   = 4'd5;
  localparam logic [3:0] FMT_ABGR32   = 4'd6;
  localparam logic [3:0] FMT_YUV444   = 4'd7;
  localparam logic [3:0] FMT_YUYV     = 4'd8;
  localparam logic [3:0] FMT_YVYU     = 4'd9;
  localparam logic [3:0] FMT_UYVY     = 4'd10;
  localparam logic [3:0] FMT_VYUY     = 4'd11;
  localparam logic [3:0] FMT_YUVA4444 = 4'd12;

  // Configuration register indexes
  localparam logic [2:0] REG_PIXEL_FORMAT = 3'd0;
  localparam logic [2:0] REG_BLEND_ENABLE = 3'd1;
  localparam logic [2:0] REG_COLOR_0      = 3'd2;
  localparam logic [2:0] REG_COLOR_1      = 3'd3;
  localparam logic [2:0] REG_COLOR_2      = 3'd4;

  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int IN_TDATA_W   = 48;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 32;
  localparam int NUM_BYTES    = 4;

  localparam logic [3:0] FMT_RESET   = FMT_Y8;
  localparam logic       BLEND_RESET = 1'b1;
  localparam logic [7:0] COLOR_RESET = 8'hFF;

  typedef logic [7:0] byte_t;

  // x / 255 for x < 65280, by reciprocal with correction
  function automatic byte_t div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

// File: rtl/glyph_coverage_pixel_blend.sv
`default_nettype none

// Glyph coverage pixel blend: writes the text color into one destination pixel
// group per transfer, weighted by 8-bit glyph coverage, for the selected pixel
// format (blend with the destination, or scale the color only). Two register
// stages (input register, result register) with a multiply-add and a
// divide-by-255 per byte lane between them; one pixel group is taken every clock
// unless both registers are full and the output is stalled, and its result
// passes the input register and then the result register before it is offered
// on out_*. The result register parts the two sides, so a stalled output still
// lets one more item in. Configuration is written through cfg_*; the user must
// write it only while the stream is idle, as the block does not enforce this.
module glyph_coverage_pixel_blend
  import gcpb_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,

  input  wire                     cfg_we,
  input  wire [CFG_ADDR_W-1:0]    cfg_addr,
  input  wire [CFG_DATA_W-1:0]    cfg_wdata,

  input  wire                     in_tvalid,
  output logic                    in_tready,
  // coverage_first, coverage_second, dest_byte_0, dest_byte_1, dest_byte_2, dest_byte_3
  input  wire [IN_TDATA_W-1:0]    in_tdata,
  // second_present, odd_start
  input  wire [IN_TUSER_W-1:0]    in_tuser,

  output logic                    out_tvalid,
  input  wire                     out_tready,
  // out_byte_0, out_byte_1, out_byte_2, out_byte_3
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  logic [3:0] pixel_format_r;
  logic       blend_enable_r;
  byte_t      color_0_r, color_1_r, color_2_r;

  logic       s1_valid_r;
  byte_t      cov_first_r, cov_second_r;
  logic       second_r, odd_r;
  byte_t      dest_r [NUM_BYTES];

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;

  logic advance;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = advance || !s1_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= FMT_RESET;
      blend_enable_r <= BLEND_RESET;
      color_0_r      <= COLOR_RESET;
      color_1_r      <= COLOR_RESET;
      color_2_r      <= COLOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PIXEL_FORMAT: pixel_format_r <= cfg_wdata[3:0];
        REG_BLEND_ENABLE: blend_enable_r <= cfg_wdata[0];
        REG_COLOR_0:      color_0_r      <= cfg_wdata;
        REG_COLOR_1:      color_1_r      <= cfg_wdata;
        REG_COLOR_2:      color_2_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cov_first_r  <= in_tdata[7:0];
      cov_second_r <= in_tdata[15:8];
      dest_r[0]    <= in_tdata[23:16];
      dest_r[1]    <= in_tdata[31:24];
      dest_r[2]    <= in_tdata[39:32];
      dest_r[3]    <= in_tdata[47:40];
      second_r     <= in_tuser[0];
      odd_r        <= in_tuser[1];
    end
  end

  // Per-lane selection of coverage and color
  byte_t ca, cb, cc;
  logic  chroma_swap;
  byte_t lane_cov [NUM_BYTES];
  byte_t lane_col [NUM_BYTES];
  logic  lane_mix [NUM_BYTES];
  logic  lane_alpha [NUM_BYTES];

  always_comb begin
    ca = color_0_r;
    cb = color_1_r;
    cc = color_2_r;
    if (pixel_format_r == FMT_BGR24 || pixel_format_r == FMT_BGRA32 ||
        pixel_format_r == FMT_ABGR32) begin
      ca = color_2_r;
      cc = color_0_r;
    end
    chroma_swap = (pixel_format_r == FMT_YUYV || pixel_format_r == FMT_UYVY) ? odd_r : !odd_r;
    if ((pixel_format_r inside {FMT_YUYV, FMT_YVYU, FMT_UYVY, FMT_VYUY}) && chroma_swap) begin
      cb = cc;
      cc = color_1_r;
    end

    for (int i = 0; i < NUM_BYTES; i++) begin
      lane_cov[i]   = cov_first_r;
      lane_col[i]   = ca;
      lane_mix[i]   = 1'b0;
      lane_alpha[i] = 1'b0;
    end

    case (pixel_format_r) inside
      FMT_Y8: begin
        lane_mix[0] = 1'b1;
      end
      FMT_RGB24, FMT_BGR24, FMT_YUV444: begin
        lane_mix[0] = 1'b1;
        lane_mix[1] = 1'b1; lane_col[1] = cb;
        lane_mix[2] = 1'b1; lane_col[2] = cc;
      end
      FMT_RGBA32, FMT_BGRA32, FMT_YUVA4444: begin
        lane_mix[0] = 1'b1;
        lane_mix[1] = 1'b1; lane_col[1] = cb;
        lane_mix[2] = 1'b1; lane_col[2] = cc;
        lane_alpha[3] = 1'b1;
      end
      FMT_ARGB32, FMT_ABGR32: begin
        lane_alpha[0] = 1'b1;
        lane_mix[1] = 1'b1; lane_col[1] = ca;
        lane_mix[2] = 1'b1; lane_col[2] = cb;
        lane_mix[3] = 1'b1; lane_col[3] = cc;
      end
      FMT_YUYV, FMT_YVYU: begin
        lane_mix[0] = 1'b1; lane_col[0] = ca;
        lane_mix[1] = 1'b1; lane_col[1] = cb;
        lane_mix[2] = second_r; lane_col[2] = ca; lane_cov[2] = cov_second_r;
        lane_mix[3] = second_r; lane_col[3] = cc; lane_cov[3] = cov_second_r;
      end
      FMT_UYVY, FMT_VYUY: begin
        lane_mix[0] = 1'b1; lane_col[0] = cb;
        lane_mix[1] = 1'b1; lane_col[1] = ca;
        lane_mix[2] = second_r; lane_col[2] = cc; lane_cov[2] = cov_second_r;
        lane_mix[3] = second_r; lane_col[3] = ca; lane_cov[3] = cov_second_r;
      end
      default: ;
    endcase
  end

  // Byte lanes: one multiply-add and divide by 255 each
  always_comb begin
    logic [15:0] dest_term, col_term, acc;
    byte_t       res;
    out_data_nxt = '0;
    for (int i = 0; i < NUM_BYTES; i++) begin
      dest_term = {8'd0, dest_r[i]} * {8'd0, 8'd255 - lane_cov[i]};
      col_term  = {8'd0, lane_col[i]} * {8'd0, lane_cov[i]};
      acc       = blend_enable_r ? (dest_term + col_term) : col_term;
      res       = dest_r[i];
      if (lane_cov[i] != 8'd0) begin
        if (lane_alpha[i]) begin
          res = 8'hFF;
        end else if (lane_mix[i]) begin
          res = div255(acc);
        end
      end
      out_data_nxt[i*8 +: 8] = res;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are full and output is stalled");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && advance) |=> out_valid_r)
    else $error("item in input stage lost on advance");

  a_alpha_forced: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r && cov_first_r != 8'd0 &&
     (pixel_format_r == FMT_RGBA32 || pixel_format_r == FMT_YUVA4444))
    |=> out_data_r[31:24] == 8'hFF)
    else $error("alpha byte not forced for covered pixel");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("pipeline valid set after reset");

endmodule

`default_nettype wire

// File: test/glyph_coverage_pixel_blend_test.sv
`timescale 1ns / 100ps

module glyph_coverage_pixel_blend_test
  import gcpb_pkg::*;
();

  localparam int          LATENCY      = 2;
  localparam int          LONG_HOLD    = 200;
  localparam int          SEGMENTS     = 31;
  localparam int          SEG_ITEMS    = 40;
  localparam logic [2:0]  REG_SPARE_LO = 3'd5;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;

  // One pixel group as it travels on the input: bits 47:0 are tdata, 49:48 tuser
  typedef struct packed {
    logic  odd_start;
    logic  second_present;
    byte_t dest_3;
    byte_t dest_2;
    byte_t dest_1;
    byte_t dest_0;
    byte_t cov_second;
    byte_t cov_first;
  } pixel_group_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  glyph_coverage_pixel_blend i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers
  logic [3:0] fmt_shadow   = FMT_RESET;
  logic       blend_shadow = BLEND_RESET;
  byte_t      color0_shadow = COLOR_RESET;
  byte_t      color1_shadow = COLOR_RESET;
  byte_t      color2_shadow = COLOR_RESET;

  pixel_group_t      pending_groups[$];
  logic [31:0]       expected_bytes[$];
  pixel_group_t      cur_group;
  logic              in_fire = 1'b0;
  int                send_idle_pct = 23;
  int                recv_idle_pct = 58;
  logic              hold_request = 1'b0;
  logic              hold_taken = 1'b0;
  int                hold_left = 0;
  int                error_count = 0;

  function automatic byte_t mix_channel(input byte_t p, input byte_t d, input byte_t c);
    int unsigned acc;
    if (p == 8'd0) return d;
    if (blend_shadow)
      acc = int'(d) * (255 - int'(p)) + int'(c) * int'(p);
    else
      acc = int'(p) * int'(c);
    return byte_t'(acc / 255);
  endfunction

  function automatic logic [31:0] blend_group(input pixel_group_t g);
    byte_t c0, c1, c2, t;
    byte_t d [4];
    byte_t r [4];
    logic  swap;
    c0 = color0_shadow;
    c1 = color1_shadow;
    c2 = color2_shadow;
    d[0] = g.dest_0;
    d[1] = g.dest_1;
    d[2] = g.dest_2;
    d[3] = g.dest_3;
    r = d;
    if (fmt_shadow == FMT_BGR24 || fmt_shadow == FMT_BGRA32 || fmt_shadow == FMT_ABGR32) begin
      t = c0; c0 = c2; c2 = t;
    end
    case (fmt_shadow)
      FMT_Y8: begin
        r[0] = mix_channel(g.cov_first, d[0], c0);
      end
      FMT_RGB24, FMT_BGR24, FMT_YUV444: begin
        r[0] = mix_channel(g.cov_first, d[0], c0);
        r[1] = mix_channel(g.cov_first, d[1], c1);
        r[2] = mix_channel(g.cov_first, d[2], c2);
      end
      FMT_RGBA32, FMT_BGRA32, FMT_YUVA4444: begin
        r[0] = mix_channel(g.cov_first, d[0], c0);
        r[1] = mix_channel(g.cov_first, d[1], c1);
        r[2] = mix_channel(g.cov_first, d[2], c2);
        if (g.cov_first != 8'd0) r[3] = 8'hFF;
      end
      FMT_ARGB32, FMT_ABGR32: begin
        if (g.cov_first != 8'd0) r[0] = 8'hFF;
        r[1] = mix_channel(g.cov_first, d[1], c0);
        r[2] = mix_channel(g.cov_first, d[2], c1);
        r[3] = mix_channel(g.cov_first, d[3], c2);
      end
      FMT_YUYV, FMT_YVYU, FMT_UYVY, FMT_VYUY: begin
        swap = (fmt_shadow == FMT_YUYV || fmt_shadow == FMT_UYVY) ? g.odd_start : !g.odd_start;
        if (swap) begin
          t = c1; c1 = c2; c2 = t;
        end
        if (fmt_shadow == FMT_YUYV || fmt_shadow == FMT_YVYU) begin
          r[0] = mix_channel(g.cov_first, d[0], c0);
          r[1] = mix_channel(g.cov_first, d[1], c1);
          if (g.second_present) begin
            r[2] = mix_channel(g.cov_second, d[2], c0);
            r[3] = mix_channel(g.cov_second, d[3], c2);
          end
        end else begin
          r[0] = mix_channel(g.cov_first, d[0], c1);
          r[1] = mix_channel(g.cov_first, d[1], c0);
          if (g.second_present) begin
            r[2] = mix_channel(g.cov_second, d[2], c2);
            r[3] = mix_channel(g.cov_second, d[3], c0);
          end
        end
      end
      default: ;
    endcase
    return {r[3], r[2], r[1], r[0]};
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Sender: hold the item until its transfer, then offer the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_groups.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_group = pending_groups.pop_front();
        in_tdata  <= cur_group[47:0];
        in_tuser  <= cur_group[49:48];
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check results first, then predict the group taken at this edge
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result %08h", out_tdata));
      end else begin
        want = expected_bytes.pop_front();
        for (int b = 0; b < NUM_BYTES; b++)
          if (out_tdata[8*b +: 8] !== want[8*b +: 8])
            report_mismatch($sformatf("out_byte_%0d got %02h want %02h",
                                      b, out_tdata[8*b +: 8], want[8*b +: 8]));
      end
    end
    if (rst_n && in_tvalid && in_tready)
      expected_bytes.push_back(blend_group(cur_group));
    in_fire <= rst_n && in_tvalid && in_tready;
  end

  task automatic set_register(input logic [2:0] idx, input byte_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_PIXEL_FORMAT: fmt_shadow    = value[3:0];
      REG_BLEND_ENABLE: blend_shadow  = value[0];
      REG_COLOR_0:      color0_shadow = value;
      REG_COLOR_1:      color1_shadow = value;
      REG_COLOR_2:      color2_shadow = value;
      default: ;
    endcase
  endtask

  // Wait for every pending transfer and result, then let the pipeline empty
  task automatic settle_block();
    while (pending_groups.size() != 0 || in_tvalid || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Bias toward the extremes, which carry the pass-through and alpha cases
  function automatic byte_t pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic pixel_group_t make_group(input byte_t cf, input byte_t cs,
                                              input logic sp, input logic os,
                                              input logic [31:0] dest);
    pixel_group_t g;
    g.cov_first      = cf;
    g.cov_second     = cs;
    g.second_present = sp;
    g.odd_start      = os;
    {g.dest_3, g.dest_2, g.dest_1, g.dest_0} = dest;
    return g;
  endfunction

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: luma only, blend, white
    pending_groups.push_back(make_group(8'h00, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
    pending_groups.push_back(make_group(8'hFF, 8'h00, 1'b0, 1'b0, 32'h0000_0000));
    pending_groups.push_back(make_group(8'h01, 8'h80, 1'b1, 1'b0, 32'h5A5A_A5A5));
    settle_block();

    // Writes beyond the register list must leave the setup alone
    set_register(REG_SPARE_LO, 8'h0F);
    set_register(REG_SPARE_HI, 8'h00);
    pending_groups.push_back(make_group(8'hFF, 8'hFF, 1'b1, 1'b1, 32'h1234_5600));
    settle_block();

    // One group per format code, unknown codes included
    set_register(REG_COLOR_0, 8'h00);
    set_register(REG_COLOR_1, 8'hFF);
    set_register(REG_COLOR_2, 8'h80);
    for (int f = 0; f < 16; f++) begin
      set_register(REG_PIXEL_FORMAT, byte_t'({4'(15 - f), 4'(f)}));
      set_register(REG_BLEND_ENABLE, (f >= 8) ? 8'hFE : 8'h01);
      pending_groups.push_back(make_group(8'hC8, 8'h32, f[0], f[1], $urandom));
      settle_block();
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < SEGMENTS / 3) begin
        send_idle_pct = 23; recv_idle_pct = 58;
      end else if (seg < 2 * SEGMENTS / 3) begin
        send_idle_pct = 58; recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      set_register(REG_PIXEL_FORMAT, byte_t'({4'($urandom), 4'($urandom_range(0, 15))}));
      set_register(REG_BLEND_ENABLE, byte_t'($urandom));
      set_register(REG_COLOR_0, pick_value());
      set_register(REG_COLOR_1, pick_value());
      set_register(REG_COLOR_2, pick_value());
      if (seg == 3) hold_request = 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++)
        pending_groups.push_back(make_group(pick_value(), pick_value(),
                                            1'($urandom_range(0, 1)),
                                            1'($urandom_range(0, 1)),
                                            {pick_value(), pick_value(),
                                             pick_value(), pick_value()}));
      settle_block();
    end

    repeat (LATENCY + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TIMEOUT at %0t", $realtime);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
